[hw/rtl/h263s_pkg.sv]
// ----------------------------------------------------------------------------
// H.263+ payload header stripper package
// Shared types and constants for the RTP payload header stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package h263s_pkg;

   localparam int unsigned POS_WIDTH = 7;
   localparam int unsigned PLEN_WIDTH = 6;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   localparam logic [POS_WIDTH-1:0] HDR_BASE_LEN = 7'd2;
   localparam logic [POS_WIDTH-1:0] POS_MAX = 7'd127;
   localparam logic [PLEN_WIDTH-1:0] PLEN_MASK = 6'h3f;
   localparam int unsigned P_BIT = 2;
   localparam int unsigned V_BIT = 1;
   localparam int unsigned PLEN_SHIFT = 3;

   // Up to two output words produced by one input word.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] data0;
      logic       last0;
      logic [7:0] data1;
      logic       last1;
   } emit_type;

endpackage

`default_nettype wire

[hw/rtl/h263s_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one packet payload byte and its end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface h263s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

`default_nettype wire

[hw/rtl/h263s_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one bitstream byte and its last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface h263s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/h263s_parser.sv]
// ----------------------------------------------------------------------------
// Payload header parser
// Tracks the byte position within a packet, decodes the payload header and
// decides which output words each accepted input word produces.
// ----------------------------------------------------------------------------
`default_nettype none

module h263s_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             end_of_packet,
   output h263s_pkg::emit_type   emit
);
   import h263s_pkg::*;

   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [7:0]            held_ff, held_in;
   logic [POS_WIDTH-1:0]  hlen_ff, hlen_in;
   logic                  prefix_ff, prefix_in;

   logic [PLEN_WIDTH-1:0] plen;
   logic [POS_WIDTH-1:0]  hdr_len_new;
   logic [POS_WIDTH-1:0]  hlen_eff;
   logic                  prefix_eff;
   logic [POS_WIDTH:0]    pos_plus1;

   always_comb begin
      plen = {held_ff[0], data_byte[7:PLEN_SHIFT]} & PLEN_MASK;
      hdr_len_new = HDR_BASE_LEN + {6'd0, held_ff[V_BIT]} + {1'b0, plen};
      hlen_eff = (pos_ff == 7'd1) ? hdr_len_new : hlen_ff;
      prefix_eff = (pos_ff == 7'd1) ? held_ff[P_BIT] : prefix_ff;
      pos_plus1 = {1'b0, pos_ff} + 8'd1;
   end

   always_comb begin
      emit = '0;
      if (pos_ff == '0) begin
         if (end_of_packet) begin
            emit.count = 2'd1;
            emit.data0 = data_byte;
            emit.last0 = 1'b1;
         end
      end else if (pos_plus1 == {1'b0, hlen_eff}) begin
         if (prefix_eff) begin
            emit.count = 2'd2;
            emit.last1 = end_of_packet;
         end
      end else if (pos_ff >= hlen_eff) begin
         emit.count = 2'd1;
         emit.data0 = data_byte;
         emit.last0 = end_of_packet;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      held_in = held_ff;
      hlen_in = hlen_ff;
      prefix_in = prefix_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            held_in = data_byte;
         end
         if (pos_ff == 7'd1) begin
            hlen_in = hdr_len_new;
            prefix_in = held_ff[P_BIT];
         end
         if (end_of_packet) begin
            pos_in = '0;
            held_in = '0;
            hlen_in = HDR_BASE_LEN;
            prefix_in = 1'b0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         held_ff <= '0;
         hlen_ff <= HDR_BASE_LEN;
         prefix_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         held_ff <= held_in;
         hlen_ff <= hlen_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/h263s_out_fifo.sv]
// ----------------------------------------------------------------------------
// Output word queue
// Small register queue that takes up to two words per cycle from the parser while it
// has room and hands one word per cycle to the response channel while it is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module h263s_out_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  h263s_pkg::emit_type       emit,
   output logic                      has_room,
   h263s_rsp_if.source               rsp
);
   import h263s_pkg::*;

   logic [7:0]                data_ff [FIFO_DEPTH];
   logic                      last_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_WIDTH-1:0] count_ff, count_in;
   logic [FIFO_PTR_WIDTH-1:0] wr_ptr_next;
   logic [1:0]                push_n;
   logic                      pop;

   always_comb begin
      push_n = push ? emit.count : 2'd0;
      pop = rsp.valid && rsp.ready;
      wr_ptr_next = wr_ptr_ff + FIFO_PTR_WIDTH'(1);
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_WIDTH'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_WIDTH'(pop);
      count_in = count_ff + FIFO_CNT_WIDTH'(push_n) - FIFO_CNT_WIDTH'(pop);
      has_room = count_ff <= FIFO_CNT_WIDTH'(FIFO_DEPTH - 2);
      rsp.valid = count_ff != '0;
      rsp.out_byte = data_ff[rd_ptr_ff];
      rsp.out_last = last_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         data_ff[wr_ptr_ff] <= emit.data0;
         last_ff[wr_ptr_ff] <= emit.last0;
      end
      if (push_n == 2'd2) begin
         data_ff[wr_ptr_next] <= emit.data1;
         last_ff[wr_ptr_next] <= emit.last1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/h263_rtp_payload_header_stripper_core.sv]
// Output: each result word is registered in the output queue before it is offered.
// Throughput: one input word per cycle while the response side keeps up; a word
// that yields the two-byte zero prefix adds a second output word, absorbed by the
// four-entry output queue, which accepts input while it has room for two words.
// Reset: synchronous; clears the packet position, header state and the queue.
// ----------------------------------------------------------------------------
// H.263+ RTP payload header stripper
// Removes the payload header, VRC byte and extra picture header from each
// packet and restores the zero start-code prefix when the P bit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module h263_rtp_payload_header_stripper_core (
   input  wire logic   clock,
   input  wire logic   reset,
   h263s_req_if.sink   req_ch,
   h263s_rsp_if.source rsp_ch
);
   import h263s_pkg::*;

   emit_type emit;
   logic     has_room;
   logic     accept;

   assign req_ch.ready = has_room;
   assign accept = req_ch.valid && has_room;

   h263s_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_ch.data_byte),
      .end_of_packet (req_ch.end_of_packet),
      .emit          (emit)
   );

   h263s_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .emit     (emit),
      .has_room (has_room),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire
